@@ rtl/core/sstk_pkg.sv @@
`default_nettype none
package sstk_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W        = 64;
  localparam int CNT_W        = 32;
  localparam int FAC_W        = 16;
  localparam int REQ_W        = 3;
  localparam int LIM_W        = 5;
  localparam int OCC_W        = 5;
  localparam int MAX_LIST     = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_HIT    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DECAY  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TOPK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PENALTY = 1'd1;

  localparam logic [FAC_W-1:0] DECAY_RESET   = 16'd32768;
  localparam logic [FAC_W-1:0] PENALTY_RESET = 16'd16384;

  typedef struct packed {
    logic load;
    logic match;
    logic walk_start;
    logic list_start;
    logic min_step;
    logic apply;
    logic decay_step;
    logic count_step;
    logic scan_step;
    logic emit;
    logic emit_none;
  } dp_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             amt_zero;
    logic             hit;
    logic             free;
    logic             idx_last;
    logic             list_done;
    logic             list_empty;
    logic             out_free;
  } dp_sts_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/sstk_if.sv @@
`default_nettype none
interface sstk_req_if;
  logic                          valid;
  logic                          ready;
  logic [sstk_pkg::REQ_W-1:0]    req_type;
  logic [sstk_pkg::KEY_W-1:0]    key;
  logic [sstk_pkg::CNT_W-1:0]    amount;
  logic [sstk_pkg::LIM_W-1:0]    topk_limit;
  logic [sstk_pkg::CNT_W-1:0]    count_floor;
  modport source (output valid, req_type, key, amount, topk_limit, count_floor,
                  input ready);
  modport sink (input valid, req_type, key, amount, topk_limit, count_floor,
                output ready);
endinterface

interface sstk_res_if;
  logic                          valid;
  logic                          ready;
  logic                          entry_valid;
  logic [sstk_pkg::KEY_W-1:0]    out_key;
  logic [sstk_pkg::CNT_W-1:0]    out_count;
  logic [sstk_pkg::CNT_W-1:0]    out_error;
  logic [sstk_pkg::OCC_W-1:0]    occupancy;
  logic [sstk_pkg::OCC_W-1:0]    qualified;
  logic                          last;
  modport source (output valid, entry_valid, out_key, out_count, out_error, occupancy,
                  qualified, last, input ready);
  modport sink (input valid, entry_valid, out_key, out_count, out_error, occupancy,
                qualified, last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sstk_ctrl.sv @@
`default_nettype none
module sstk_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output sstk_pkg::dp_cmd_t       cmd,
  input  wire sstk_pkg::dp_sts_t  sts
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MATCH = 4'd1;
  localparam logic [3:0] S_ROUTE = 4'd2;
  localparam logic [3:0] S_MINW  = 4'd3;
  localparam logic [3:0] S_APPLY = 4'd4;
  localparam logic [3:0] S_DECAY = 4'd5;
  localparam logic [3:0] S_COUNT = 4'd6;
  localparam logic [3:0] S_POST  = 4'd7;
  localparam logic [3:0] S_SCAN  = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_NONE  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = S_ROUTE;
      end
      S_ROUTE: begin
        unique case (sts.req_type) inside
          sstk_pkg::REQ_UPDATE: begin
            if (sts.amt_zero) begin
              cmd.walk_start = 1'b1;
              state_next     = S_COUNT;
            end else if (sts.hit || sts.free) begin
              state_next = S_APPLY;
            end else begin
              cmd.walk_start = 1'b1;
              state_next     = S_MINW;
            end
          end
          sstk_pkg::REQ_HIT, sstk_pkg::REQ_CLEAR: state_next = S_APPLY;
          sstk_pkg::REQ_DECAY: begin
            cmd.walk_start = 1'b1;
            state_next     = S_DECAY;
          end
          default: begin
            cmd.walk_start = 1'b1;
            state_next     = S_COUNT;
          end
        endcase
      end
      S_MINW: begin
        cmd.min_step = 1'b1;
        if (sts.idx_last) state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply      = 1'b1;
        cmd.walk_start = 1'b1;
        state_next     = S_COUNT;
      end
      S_DECAY: begin
        cmd.decay_step = 1'b1;
        if (sts.idx_last) begin
          cmd.walk_start = 1'b1;
          state_next     = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd.count_step = 1'b1;
        if (sts.idx_last) state_next = S_POST;
      end
      S_POST: begin
        if (sts.req_type == sstk_pkg::REQ_TOPK && !sts.list_empty) begin
          cmd.walk_start = 1'b1;
          cmd.list_start = 1'b1;
          state_next     = S_SCAN;
        end else begin
          state_next = S_NONE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.idx_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.list_done) begin
            state_next = S_IDLE;
          end else begin
            cmd.walk_start = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_NONE: begin
        if (sts.out_free) begin
          cmd.emit_none = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/sstk_dp.sv @@
`default_nettype none
module sstk_dp #(
  parameter int CAPACITY = sstk_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire sstk_pkg::dp_cmd_t                 cmd,
  output sstk_pkg::dp_sts_t                      sts,
  input  wire logic [sstk_pkg::REQ_W-1:0]        in_req_type,
  input  wire logic [sstk_pkg::KEY_W-1:0]        in_key,
  input  wire logic [sstk_pkg::CNT_W-1:0]        in_amount,
  input  wire logic [sstk_pkg::LIM_W-1:0]        in_topk_limit,
  input  wire logic [sstk_pkg::CNT_W-1:0]        in_count_floor,
  input  wire logic                              cfg_we,
  input  wire logic [sstk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sstk_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output logic                                   res_entry_valid,
  output logic [sstk_pkg::KEY_W-1:0]             res_key,
  output logic [sstk_pkg::CNT_W-1:0]             res_count,
  output logic [sstk_pkg::CNT_W-1:0]             res_error,
  output logic [sstk_pkg::OCC_W-1:0]             res_occupancy,
  output logic [sstk_pkg::OCC_W-1:0]             res_qualified,
  output logic                                   res_last
);

  localparam int IW = $clog2(CAPACITY);
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int PW = sstk_pkg::CNT_W + sstk_pkg::FAC_W;
  localparam int KW = sstk_pkg::KEY_W;
  localparam int CW = sstk_pkg::CNT_W;
  localparam int LW = sstk_pkg::LIM_W;
  localparam int SW = sstk_pkg::OCC_W;

  logic [CAPACITY-1:0]  slot_valid;
  logic [CAPACITY-1:0]  slot_pen;
  logic [CAPACITY-1:0]  taken;
  logic [KW-1:0]        slot_key   [CAPACITY];
  logic [CW-1:0]        slot_count [CAPACITY];
  logic [CW-1:0]        slot_error [CAPACITY];

  logic [sstk_pkg::FAC_W-1:0] dec_fac;
  logic [sstk_pkg::FAC_W-1:0] pen_fac;

  logic [sstk_pkg::REQ_W-1:0] req_q;
  logic [KW-1:0]              key_q;
  logic [CW-1:0]              amt_q;
  logic [LW-1:0]              lim_q;
  logic [CW-1:0]              minc_q;

  logic          hit_q, free_q;
  logic [IW-1:0] hit_idx, free_idx;
  logic [IW-1:0] idx;
  logic          min_found, best_found;
  logic [IW-1:0] min_idx, best_idx;
  logic [CW-1:0] min_cnt, best_cnt;
  logic [KW-1:0] min_key, best_key;
  logic [OW-1:0] occ, qual;
  logic [LW-1:0] nlisted;

  logic          m_hit, f_hit;
  logic [IW-1:0] m_idx, f_idx, ins_idx;
  logic          rd_valid, rd_pen;
  logic [KW-1:0] rd_key;
  logic [CW-1:0] rd_cnt, rd_err;
  logic          min_better, cand;
  logic [sstk_pkg::FAC_W-1:0] fac;
  logic [PW-1:0] prod_c, prod_e;
  logic [CW-1:0] new_c, new_e;
  logic [SW-1:0] occ_sat, qual_sat, lim_cap, total;
  logic          idx_last, list_done;

  always_comb begin
    m_hit = 1'b0;
    m_idx = '0;
    f_hit = 1'b0;
    f_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_key[i] == key_q) begin
        m_hit = 1'b1;
        m_idx = IW'(i);
      end
      if (!slot_valid[i]) begin
        f_hit = 1'b1;
        f_idx = IW'(i);
      end
    end
  end

  assign ins_idx  = free_q ? free_idx : min_idx;
  assign rd_valid = slot_valid[idx];
  assign rd_pen   = slot_pen[idx];
  assign rd_key   = slot_key[idx];
  assign rd_cnt   = slot_count[idx];
  assign rd_err   = slot_error[idx];
  assign idx_last = (idx == IW'(CAPACITY - 1));

  assign min_better = rd_valid && (!min_found || rd_cnt < min_cnt ||
                                   (rd_cnt == min_cnt && rd_key < min_key));
  assign cand = rd_valid && !taken[idx] && rd_cnt >= minc_q &&
                (!best_found || rd_cnt > best_cnt ||
                 (rd_cnt == best_cnt && rd_key > best_key));

  assign fac    = rd_pen ? pen_fac : dec_fac;
  assign prod_c = PW'(rd_cnt) * PW'(fac);
  assign prod_e = PW'(rd_err) * PW'(fac);
  assign new_c  = prod_c[PW-1:sstk_pkg::FAC_W];
  assign new_e  = prod_e[PW-1:sstk_pkg::FAC_W];

  assign occ_sat   = (32'(occ) > 32'd31) ? 5'd31 : SW'(occ);
  assign qual_sat  = (32'(qual) > 32'd31) ? 5'd31 : SW'(qual);
  assign lim_cap   = (lim_q > LW'(sstk_pkg::MAX_LIST)) ? LW'(sstk_pkg::MAX_LIST) : lim_q;
  assign total     = (lim_cap < qual_sat) ? lim_cap : qual_sat;
  assign list_done = (LW'(nlisted + LW'(1)) == total);

  always_comb begin
    sts.req_type   = req_q;
    sts.amt_zero   = (amt_q == '0);
    sts.hit        = hit_q;
    sts.free       = free_q;
    sts.idx_last   = idx_last;
    sts.list_done  = list_done;
    sts.list_empty = (total == '0);
    sts.out_free   = !res_valid || res_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_fac    <= sstk_pkg::DECAY_RESET;
      pen_fac    <= sstk_pkg::PENALTY_RESET;
      slot_valid <= '0;
      slot_pen   <= '0;
      taken      <= '0;
      nlisted    <= '0;
      res_valid  <= 1'b0;
      idx        <= '0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      min_found  <= 1'b0;
      best_found <= 1'b0;
      occ        <= '0;
      qual       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sstk_pkg::CFG_DECAY:   dec_fac <= cfg_data;
          sstk_pkg::CFG_PENALTY: pen_fac <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.match) begin
        hit_q  <= m_hit;
        free_q <= f_hit;
      end
      if (cmd.load) begin
        occ  <= '0;
        qual <= '0;
      end
      if (cmd.walk_start) begin
        idx        <= '0;
        min_found  <= 1'b0;
        best_found <= 1'b0;
      end else begin
        if (cmd.min_step || cmd.decay_step || cmd.count_step || cmd.scan_step) begin
          idx <= idx_last ? '0 : idx + IW'(1);
        end
        if (cmd.min_step && min_better) min_found <= 1'b1;
        if (cmd.scan_step && cand) best_found <= 1'b1;
        if (cmd.count_step && rd_valid) begin
          occ <= occ + OW'(1);
          if (rd_cnt >= minc_q) qual <= qual + OW'(1);
        end
      end
      if (cmd.list_start) begin
        taken   <= '0;
        nlisted <= '0;
      end
      if (cmd.emit) begin
        taken[best_idx] <= 1'b1;
        nlisted         <= nlisted + LW'(1);
      end
      if (cmd.apply) begin
        unique case (req_q)
          sstk_pkg::REQ_UPDATE: begin
            if (!hit_q) begin
              slot_valid[ins_idx] <= 1'b1;
              slot_pen[ins_idx]   <= 1'b0;
            end
          end
          sstk_pkg::REQ_HIT: begin
            if (amt_q == '0) begin
              if (hit_q) slot_pen[hit_idx] <= 1'b1;
            end else if (hit_q) begin
              slot_pen[hit_idx] <= 1'b0;
            end else if (free_q) begin
              slot_valid[free_idx] <= 1'b1;
              slot_pen[free_idx]   <= 1'b0;
            end
          end
          sstk_pkg::REQ_CLEAR: begin
            slot_valid <= '0;
            slot_pen   <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.decay_step) begin
        if (rd_valid && new_c == '0) slot_valid[idx] <= 1'b0;
        slot_pen[idx] <= 1'b0;
      end
      if (cmd.emit || cmd.emit_none) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= in_req_type;
      key_q  <= in_key;
      amt_q  <= in_amount;
      lim_q  <= in_topk_limit;
      minc_q <= in_count_floor;
    end
    if (cmd.match) begin
      hit_idx  <= m_idx;
      free_idx <= f_idx;
    end
    if (cmd.min_step && min_better) begin
      min_idx <= idx;
      min_cnt <= rd_cnt;
      min_key <= rd_key;
    end
    if (cmd.scan_step && cand) begin
      best_idx <= idx;
      best_cnt <= rd_cnt;
      best_key <= rd_key;
    end
    if (cmd.apply) begin
      unique case (req_q)
        sstk_pkg::REQ_UPDATE: begin
          if (hit_q) begin
            slot_count[hit_idx] <= sstk_pkg::sat_add(slot_count[hit_idx], amt_q);
          end else if (free_q) begin
            slot_key[free_idx]   <= key_q;
            slot_count[free_idx] <= amt_q;
            slot_error[free_idx] <= '0;
          end else begin
            slot_key[min_idx]   <= key_q;
            slot_count[min_idx] <= sstk_pkg::sat_add(min_cnt, amt_q);
            slot_error[min_idx] <= min_cnt;
          end
        end
        sstk_pkg::REQ_HIT: begin
          if (amt_q != '0) begin
            if (hit_q) begin
              slot_count[hit_idx] <= sstk_pkg::sat_add(slot_count[hit_idx], amt_q);
            end else if (free_q) begin
              slot_key[free_idx]   <= key_q;
              slot_count[free_idx] <= amt_q;
              slot_error[free_idx] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
    if (cmd.decay_step && rd_valid) begin
      slot_count[idx] <= new_c;
      slot_error[idx] <= new_e;
    end
    if (cmd.emit) begin
      res_entry_valid <= 1'b1;
      res_key         <= best_key;
      res_count       <= best_cnt;
      res_error       <= slot_error[best_idx];
      res_occupancy   <= occ_sat;
      res_qualified   <= qual_sat;
      res_last        <= list_done;
    end else if (cmd.emit_none) begin
      res_entry_valid <= 1'b0;
      res_key         <= '0;
      res_count       <= '0;
      res_error       <= '0;
      res_occupancy   <= occ_sat;
      res_qualified   <= qual_sat;
      res_last        <= 1'b1;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OW'(CAPACITY))
    else $error("occupancy count exceeds capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && req_q == sstk_pkg::REQ_CLEAR) |=> (slot_valid == '0))
    else $error("clear left valid slots");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_none) |-> (!res_valid || res_ready))
    else $error("result register overwritten");

  a_emit_found: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (best_found && !taken[best_idx]))
    else $error("listed entry without a fresh candidate");

endmodule
`default_nettype wire

@@ rtl/core/space_saving_topk_tracker_core.sv @@
// Each request is loaded, matched and routed. An update, hit report or clear is then
// applied (an update of zero skips this step); an eviction first walks the table for
// the minimum entry. Decay walks the table to scale every entry. Every request then
// walks the table to count entries; top-k rescans the table for each listed entry.
// One request is in work at a time; the next is accepted in the cycle after the final
// result is issued, and a waiting result stalls only the next issue. Reset empties
// the table and loads the factors.
`default_nettype none
module space_saving_topk_tracker_core #(
  parameter int CAPACITY = sstk_pkg::CAPACITY_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  sstk_req_if.sink                               req,
  sstk_res_if.source                             res,
  input  wire logic                              cfg_we,
  input  wire logic [sstk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sstk_pkg::CFG_DATA_W-1:0]   cfg_data
);

  sstk_pkg::dp_cmd_t cmd;
  sstk_pkg::dp_sts_t sts;
  logic              in_ready;

  assign req.ready = in_ready;

  sstk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  sstk_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (req.req_type),
    .in_key          (req.key),
    .in_amount       (req.amount),
    .in_topk_limit   (req.topk_limit),
    .in_count_floor  (req.count_floor),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_entry_valid (res.entry_valid),
    .res_key         (res.out_key),
    .res_count       (res.out_count),
    .res_error       (res.out_error),
    .res_occupancy   (res.occupancy),
    .res_qualified   (res.qualified),
    .res_last        (res.last)
  );

endmodule
`default_nettype wire

@@ dv/space_saving_topk_tracker_core_test.sv @@
`default_nettype none
module space_saving_topk_tracker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = sstk_pkg::CAPACITY_DEF;
  localparam logic [sstk_pkg::REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [sstk_pkg::REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic                       entry_valid;
    logic [sstk_pkg::KEY_W-1:0] out_key;
    logic [sstk_pkg::CNT_W-1:0] out_count;
    logic [sstk_pkg::CNT_W-1:0] out_error;
    logic [sstk_pkg::OCC_W-1:0] occupancy;
    logic [sstk_pkg::OCC_W-1:0] qualified;
    logic                       last;
  } listing_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [sstk_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sstk_pkg::CFG_DATA_W-1:0] cfg_data;

  sstk_req_if req ();
  sstk_res_if res ();

  space_saving_topk_tracker_core DUT (
    .clk(clk), .rst(rst), .req(req), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bit                         tbl_valid [NSLOT];
  logic [sstk_pkg::KEY_W-1:0] tbl_key  [NSLOT];
  logic [sstk_pkg::CNT_W-1:0] tbl_count[NSLOT];
  logic [sstk_pkg::CNT_W-1:0] tbl_error[NSLOT];
  bit                         tbl_mark [NSLOT];
  logic [sstk_pkg::FAC_W-1:0] decay_q;
  logic [sstk_pkg::FAC_W-1:0] penalty_q;

  listing_t expected_listing[$];
  int errors;
  int stall_left;
  bit sink_stall_en;
  bit src_idle_en;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("FAIL space_saving_topk_tracker_core");
    $finish;
  end

  function automatic logic [sstk_pkg::CNT_W-1:0] add_sat(logic [sstk_pkg::CNT_W-1:0] a,
                                                         logic [sstk_pkg::CNT_W-1:0] b);
    logic [sstk_pkg::CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[sstk_pkg::CNT_W] ? '1 : s[sstk_pkg::CNT_W-1:0];
  endfunction

  function automatic logic [sstk_pkg::CNT_W-1:0] scale_by(logic [sstk_pkg::CNT_W-1:0] v,
                                                          logic [sstk_pkg::FAC_W-1:0] f);
    logic [63:0] p;
    p = 64'(v) * 64'(f);
    return p[47:16];
  endfunction

  task automatic predict_table(input logic [sstk_pkg::REQ_W-1:0] op,
                               input logic [sstk_pkg::KEY_W-1:0] k,
                               input logic [sstk_pkg::CNT_W-1:0] amt,
                               input logic [sstk_pkg::LIM_W-1:0] lim,
                               input logic [sstk_pkg::CNT_W-1:0] minc);
    int hit, free, m, b, n, occ, qual, cap;
    bit taken[NSLOT];
    listing_t r;
    hit = -1; free = -1; m = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (tbl_valid[i] && tbl_key[i] == k && hit < 0) hit = i;
      if (!tbl_valid[i] && free < 0) free = i;
      if (tbl_valid[i] && (m < 0 || tbl_count[i] < tbl_count[m] ||
          (tbl_count[i] == tbl_count[m] && tbl_key[i] < tbl_key[m]))) m = i;
    end
    case (op)
      sstk_pkg::REQ_UPDATE: begin
        if (amt != 0) begin
          if (hit >= 0) tbl_count[hit] = add_sat(tbl_count[hit], amt);
          else if (free >= 0) begin
            tbl_valid[free] = 1; tbl_key[free] = k; tbl_count[free] = amt;
            tbl_error[free] = 0; tbl_mark[free] = 0;
          end else begin
            tbl_key[m] = k; tbl_error[m] = tbl_count[m];
            tbl_count[m] = add_sat(tbl_count[m], amt); tbl_mark[m] = 0;
          end
        end
      end
      sstk_pkg::REQ_HIT: begin
        if (amt == 0) begin
          if (hit >= 0) tbl_mark[hit] = 1;
        end else if (hit >= 0) begin
          tbl_count[hit] = add_sat(tbl_count[hit], amt); tbl_mark[hit] = 0;
        end else if (free >= 0) begin
          tbl_valid[free] = 1; tbl_key[free] = k; tbl_count[free] = amt;
          tbl_error[free] = 0; tbl_mark[free] = 0;
        end
      end
      sstk_pkg::REQ_DECAY: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (tbl_valid[i]) begin
            tbl_count[i] = scale_by(tbl_count[i], tbl_mark[i] ? penalty_q : decay_q);
            tbl_error[i] = scale_by(tbl_error[i], tbl_mark[i] ? penalty_q : decay_q);
            if (tbl_count[i] == 0) tbl_valid[i] = 0;
          end
          tbl_mark[i] = 0;
        end
      end
      sstk_pkg::REQ_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) begin
          tbl_valid[i] = 0; tbl_mark[i] = 0;
        end
      end
      default: ;
    endcase
    occ = 0; qual = 0;
    for (int i = 0; i < NSLOT; i++) if (tbl_valid[i]) begin
      occ++;
      if (tbl_count[i] >= minc) qual++;
    end
    n = 0;
    if (op == sstk_pkg::REQ_TOPK) begin
      cap = (lim > sstk_pkg::MAX_LIST) ? sstk_pkg::MAX_LIST : int'(lim);
      for (int i = 0; i < NSLOT; i++) taken[i] = 0;
      while (n < cap) begin
        b = -1;
        for (int i = 0; i < NSLOT; i++) begin
          if (!tbl_valid[i] || taken[i] || tbl_count[i] < minc) continue;
          if (b < 0 || tbl_count[i] > tbl_count[b] ||
              (tbl_count[i] == tbl_count[b] && tbl_key[i] > tbl_key[b])) b = i;
        end
        if (b < 0) break;
        taken[b] = 1;
        r = '{1'b1, tbl_key[b], tbl_count[b], tbl_error[b],
              sstk_pkg::OCC_W'(occ), sstk_pkg::OCC_W'(qual), 1'b0};
        expected_listing.insert(expected_listing.size(), r);
        n++;
      end
      if (n > 0) begin
        r = expected_listing[expected_listing.size() - 1];
        r.last = 1'b1;
        expected_listing[expected_listing.size() - 1] = r;
      end
    end
    if (n == 0) begin
      r = '{1'b0, '0, '0, '0, sstk_pkg::OCC_W'(occ), sstk_pkg::OCC_W'(qual), 1'b1};
      expected_listing.insert(expected_listing.size(), r);
    end
  endtask

  task automatic send_request(input logic [sstk_pkg::REQ_W-1:0] op,
                              input logic [sstk_pkg::KEY_W-1:0] k,
                              input logic [sstk_pkg::CNT_W-1:0] amt,
                              input logic [sstk_pkg::LIM_W-1:0] lim,
                              input logic [sstk_pkg::CNT_W-1:0] minc);
    if (src_idle_en && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 6)) @(posedge clk);
    predict_table(op, k, amt, lim, minc);
    req.valid <= 1'b1;
    req.req_type <= op;
    req.key <= k;
    req.amount <= amt;
    req.topk_limit <= lim;
    req.count_floor <= minc;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (expected_listing.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_factor(input logic [sstk_pkg::CFG_IDX_W-1:0] idx,
                              input logic [sstk_pkg::FAC_W-1:0] v);
    drain_results();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sstk_pkg::CFG_DECAY) decay_q = v; else penalty_q = v;
  endtask

  always @(posedge clk) begin
    listing_t got, want;
    if (!rst) begin
      if (res.valid && res.ready) begin
        got = '{res.entry_valid, res.out_key, res.out_count, res.out_error,
                res.occupancy, res.qualified, res.last};
        if (expected_listing.size() == 0) begin
          $display("%0t unexpected transfer %h", $time, got);
          errors++;
        end else begin
          want = expected_listing.pop_front();
          if (got !== want) begin
            $display("%0t mismatch expected %h actual %h", $time, want, got);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        res.ready <= 1'b0;
        stall_left--;
      end else if (sink_stall_en && $urandom_range(0, 7) == 0) begin
        res.ready <= 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  function automatic logic [sstk_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
    return sstk_pkg::KEY_W'($urandom_range(0, 23)) |
           (sstk_pkg::KEY_W'($urandom_range(0, 1)) << 63);
  endfunction

  function automatic logic [sstk_pkg::CNT_W-1:0] pick_amount();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return $urandom;
      2: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  task automatic test_directed();
    send_request(sstk_pkg::REQ_TOPK, 0, 0, 16, 0);
    send_request(sstk_pkg::REQ_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_request(sstk_pkg::REQ_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, 5, 0, 0);
    send_request(sstk_pkg::REQ_UPDATE, 0, 0, 0, 0);
    send_request(sstk_pkg::REQ_UPDATE, 0, 7, 0, 0);
    send_request(sstk_pkg::REQ_HIT, 1, 9, 0, 0);
    send_request(sstk_pkg::REQ_HIT, 1, 0, 0, 0);
    send_request(sstk_pkg::REQ_HIT, 99, 0, 0, 0);
    for (int i = 2; i < 16; i++) send_request(sstk_pkg::REQ_UPDATE, i, 7, 0, 0);
    send_request(sstk_pkg::REQ_UPDATE, 200, 3, 0, 0);
    send_request(sstk_pkg::REQ_HIT, 201, 4, 0, 0);
    send_request(sstk_pkg::REQ_TOPK, 0, 0, 31, 8);
    send_request(sstk_pkg::REQ_DECAY, 0, 0, 0, 32'hFFFF_FFFF);
    send_request(REQ_SPARE_FIRST, 0, 0, 0, 0);
    send_request(REQ_SPARE_LAST, '1, '1, '1, '1);
    send_request(sstk_pkg::REQ_TOPK, 0, 0, 3, 0);
    send_request(sstk_pkg::REQ_CLEAR, 0, 0, 0, 0);
  endtask

  task automatic test_random(input int count);
    logic [sstk_pkg::REQ_W-1:0] op;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) op = sstk_pkg::REQ_UPDATE;
      else if (sel < 70) op = sstk_pkg::REQ_HIT;
      else if (sel < 80) op = sstk_pkg::REQ_DECAY;
      else if (sel < 93) op = sstk_pkg::REQ_TOPK;
      else if (sel < 96) op = sstk_pkg::REQ_CLEAR;
      else op = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
      send_request(op, pick_key(), pick_amount(), 5'($urandom),
                   ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 600));
      if (i == count / 2) drain_results();
    end
  endtask

  task automatic test_factor_sweep();
    write_factor(sstk_pkg::CFG_DECAY, 16'd1);
    write_factor(sstk_pkg::CFG_PENALTY, 16'hFFFF);
    test_random(100);
    write_factor(sstk_pkg::CFG_DECAY, 16'hFFFF);
    write_factor(sstk_pkg::CFG_PENALTY, 16'd1);
    test_random(100);
    write_factor(sstk_pkg::CFG_DECAY, 16'($urandom_range(1, 65535)));
    write_factor(sstk_pkg::CFG_PENALTY, 16'($urandom_range(1, 65535)));
    test_random(80);
  endtask

  initial begin
    errors = 0;
    stall_left = 0;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    req.valid = 1'b0; req.req_type = '0; req.key = '0; req.amount = '0;
    req.topk_limit = '0; req.count_floor = '0;
    res.ready = 1'b0;
    decay_q = sstk_pkg::DECAY_RESET; penalty_q = sstk_pkg::PENALTY_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_valid[i] = 0; tbl_mark[i] = 0;
      tbl_key[i] = 0; tbl_count[i] = 0; tbl_error[i] = 0;
    end
    src_idle_en = 1; sink_stall_en = 1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(100);
    test_factor_sweep();
    src_idle_en = 0; sink_stall_en = 0;
    test_random(40);
    drain_results();
    if (errors == 0) $display("PASS space_saving_topk_tracker_core");
    else $display("FAIL space_saving_topk_tracker_core");
    $finish;
  end
endmodule
`default_nettype wire
